[design/cpu6502_instruction_predecoder_macros.svh]
// Assertion macros shared by the predecoder RTL.
`ifndef CPU6502_INSTRUCTION_PREDECODER_MACROS_SVH
`define CPU6502_INSTRUCTION_PREDECODER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define P65_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that a trigger implies a consequence in the next cycle.
`define P65_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[design/p65_pkg.sv]
// Opcode table, mnemonic and addressing mode codes for the 6502 predecoder.
package p65_pkg;

    typedef logic [5:0] t_mnem;
    typedef logic [3:0] t_mode;

    // Addressing modes
    localparam t_mode AM_IMP  = 4'd0;
    localparam t_mode AM_ACC  = 4'd1;
    localparam t_mode AM_IMM  = 4'd2;
    localparam t_mode AM_ZP   = 4'd3;
    localparam t_mode AM_ZPX  = 4'd4;
    localparam t_mode AM_ZPY  = 4'd5;
    localparam t_mode AM_ABS  = 4'd6;
    localparam t_mode AM_ABX  = 4'd7;
    localparam t_mode AM_ABY  = 4'd8;
    localparam t_mode AM_IND  = 4'd9;
    localparam t_mode AM_IZX  = 4'd10;
    localparam t_mode AM_IZY  = 4'd11;
    localparam t_mode AM_REL  = 4'd12;
    localparam t_mode AM_ZPI  = 4'd13;

    // Mnemonics, alphabetical
    localparam t_mnem MN_ADC = 6'd0,  MN_AND = 6'd1,  MN_ASL = 6'd2,  MN_BCC = 6'd3;
    localparam t_mnem MN_BCS = 6'd4,  MN_BEQ = 6'd5,  MN_BIT = 6'd6,  MN_BMI = 6'd7;
    localparam t_mnem MN_BNE = 6'd8,  MN_BPL = 6'd9,  MN_BRK = 6'd10, MN_BVC = 6'd11;
    localparam t_mnem MN_BVS = 6'd12, MN_CLC = 6'd13, MN_CLD = 6'd14, MN_CLI = 6'd15;
    localparam t_mnem MN_CLV = 6'd16, MN_CMP = 6'd17, MN_CPX = 6'd18, MN_CPY = 6'd19;
    localparam t_mnem MN_DEC = 6'd20, MN_DEX = 6'd21, MN_DEY = 6'd22, MN_EOR = 6'd23;
    localparam t_mnem MN_INC = 6'd24, MN_INX = 6'd25, MN_INY = 6'd26, MN_JMP = 6'd27;
    localparam t_mnem MN_JSR = 6'd28, MN_LDA = 6'd29, MN_LDX = 6'd30, MN_LDY = 6'd31;
    localparam t_mnem MN_LSR = 6'd32, MN_NOP = 6'd33, MN_ORA = 6'd34, MN_PHA = 6'd35;
    localparam t_mnem MN_PHP = 6'd36, MN_PLA = 6'd37, MN_PLP = 6'd38, MN_ROL = 6'd39;
    localparam t_mnem MN_ROR = 6'd40, MN_RTI = 6'd41, MN_RTS = 6'd42, MN_SBC = 6'd43;
    localparam t_mnem MN_SEC = 6'd44, MN_SED = 6'd45, MN_SEI = 6'd46, MN_STA = 6'd47;
    localparam t_mnem MN_STX = 6'd48, MN_STY = 6'd49, MN_TAX = 6'd50, MN_TAY = 6'd51;
    localparam t_mnem MN_TSX = 6'd52, MN_TXA = 6'd53, MN_TXS = 6'd54, MN_TYA = 6'd55;

    // Configuration register indexes
    localparam logic CFG_START = 1'b0;
    localparam logic CFG_END   = 1'b1;

    typedef struct packed {
        logic  valid;
        t_mnem mnem;
        t_mode mode;
    } t_op_info;

    // Instruction length in bytes for an addressing mode
    function automatic logic [1:0] mode_length(input t_mode mode);
        logic [1:0] len;
        if (mode == AM_IMP || mode == AM_ACC) begin
            len = 2'd1;
        end else if (mode == AM_ABS || mode == AM_ABX || mode == AM_ABY || mode == AM_IND) begin
            len = 2'd3;
        end else begin
            len = 2'd2;
        end
        return len;
    endfunction

    // Opcode lookup; unknown opcodes come back invalid with zero fields
    function automatic t_op_info decode_op(input logic [7:0] op);
        t_op_info r;
        unique case (op)
            8'h69: r = '{1'b1, MN_ADC, AM_IMM};  8'h65: r = '{1'b1, MN_ADC, AM_ZP};
            8'h75: r = '{1'b1, MN_ADC, AM_ZPX};  8'h6D: r = '{1'b1, MN_ADC, AM_ABS};
            8'h7D: r = '{1'b1, MN_ADC, AM_ABX};  8'h79: r = '{1'b1, MN_ADC, AM_ABY};
            8'h61: r = '{1'b1, MN_ADC, AM_IZX};  8'h71: r = '{1'b1, MN_ADC, AM_IZY};
            8'h29: r = '{1'b1, MN_AND, AM_IMM};  8'h25: r = '{1'b1, MN_AND, AM_ZP};
            8'h35: r = '{1'b1, MN_AND, AM_ZPX};  8'h2D: r = '{1'b1, MN_AND, AM_ABS};
            8'h3D: r = '{1'b1, MN_AND, AM_ABX};  8'h39: r = '{1'b1, MN_AND, AM_ABY};
            8'h21: r = '{1'b1, MN_AND, AM_IZX};  8'h31: r = '{1'b1, MN_AND, AM_IZY};
            8'h0A: r = '{1'b1, MN_ASL, AM_ACC};  8'h06: r = '{1'b1, MN_ASL, AM_ZP};
            8'h16: r = '{1'b1, MN_ASL, AM_ZPX};  8'h0E: r = '{1'b1, MN_ASL, AM_ABS};
            8'h1E: r = '{1'b1, MN_ASL, AM_ABX};
            8'h90: r = '{1'b1, MN_BCC, AM_REL};  8'hB0: r = '{1'b1, MN_BCS, AM_REL};
            8'hF0: r = '{1'b1, MN_BEQ, AM_REL};  8'h24: r = '{1'b1, MN_BIT, AM_ZP};
            8'h2C: r = '{1'b1, MN_BIT, AM_ABS};  8'h30: r = '{1'b1, MN_BMI, AM_REL};
            8'hD0: r = '{1'b1, MN_BNE, AM_REL};  8'h10: r = '{1'b1, MN_BPL, AM_REL};
            8'h00: r = '{1'b1, MN_BRK, AM_IMP};  8'h50: r = '{1'b1, MN_BVC, AM_REL};
            8'h70: r = '{1'b1, MN_BVS, AM_REL};
            8'h18: r = '{1'b1, MN_CLC, AM_IMP};  8'hD8: r = '{1'b1, MN_CLD, AM_IMP};
            8'h58: r = '{1'b1, MN_CLI, AM_IMP};  8'hB8: r = '{1'b1, MN_CLV, AM_IMP};
            8'hC9: r = '{1'b1, MN_CMP, AM_IMM};  8'hC5: r = '{1'b1, MN_CMP, AM_ZP};
            8'hD5: r = '{1'b1, MN_CMP, AM_ZPX};  8'hCD: r = '{1'b1, MN_CMP, AM_ABS};
            8'hDD: r = '{1'b1, MN_CMP, AM_ABX};  8'hD9: r = '{1'b1, MN_CMP, AM_ABY};
            8'hC1: r = '{1'b1, MN_CMP, AM_IZX};  8'hD1: r = '{1'b1, MN_CMP, AM_IZY};
            8'hE0: r = '{1'b1, MN_CPX, AM_IMM};  8'hE4: r = '{1'b1, MN_CPX, AM_ZP};
            8'hEC: r = '{1'b1, MN_CPX, AM_ABS};  8'hC0: r = '{1'b1, MN_CPY, AM_IMM};
            8'hC4: r = '{1'b1, MN_CPY, AM_ZP};   8'hCC: r = '{1'b1, MN_CPY, AM_ABS};
            8'hC6: r = '{1'b1, MN_DEC, AM_ZP};   8'hD6: r = '{1'b1, MN_DEC, AM_ZPX};
            8'hCE: r = '{1'b1, MN_DEC, AM_ABS};  8'hDE: r = '{1'b1, MN_DEC, AM_ABX};
            8'hCA: r = '{1'b1, MN_DEX, AM_IMP};  8'h88: r = '{1'b1, MN_DEY, AM_IMP};
            8'h49: r = '{1'b1, MN_EOR, AM_IMM};  8'h45: r = '{1'b1, MN_EOR, AM_ZP};
            8'h55: r = '{1'b1, MN_EOR, AM_ZPX};  8'h4D: r = '{1'b1, MN_EOR, AM_ABS};
            8'h5D: r = '{1'b1, MN_EOR, AM_ABX};  8'h59: r = '{1'b1, MN_EOR, AM_ABY};
            8'h41: r = '{1'b1, MN_EOR, AM_IZX};  8'h51: r = '{1'b1, MN_EOR, AM_IZY};
            8'hE6: r = '{1'b1, MN_INC, AM_ZP};   8'hF6: r = '{1'b1, MN_INC, AM_ZPX};
            8'hEE: r = '{1'b1, MN_INC, AM_ABS};  8'hFE: r = '{1'b1, MN_INC, AM_ABX};
            8'hE8: r = '{1'b1, MN_INX, AM_IMP};  8'hC8: r = '{1'b1, MN_INY, AM_IMP};
            8'h4C: r = '{1'b1, MN_JMP, AM_ABS};  8'h6C: r = '{1'b1, MN_JMP, AM_IND};
            8'h20: r = '{1'b1, MN_JSR, AM_ABS};
            8'hA9: r = '{1'b1, MN_LDA, AM_IMM};  8'hA5: r = '{1'b1, MN_LDA, AM_ZP};
            8'hB5: r = '{1'b1, MN_LDA, AM_ZPX};  8'hAD: r = '{1'b1, MN_LDA, AM_ABS};
            8'hBD: r = '{1'b1, MN_LDA, AM_ABX};  8'hB9: r = '{1'b1, MN_LDA, AM_ABY};
            8'hA1: r = '{1'b1, MN_LDA, AM_IZX};  8'hB1: r = '{1'b1, MN_LDA, AM_IZY};
            8'hA2: r = '{1'b1, MN_LDX, AM_IMM};  8'hA6: r = '{1'b1, MN_LDX, AM_ZP};
            8'hB6: r = '{1'b1, MN_LDX, AM_ZPY};  8'hAE: r = '{1'b1, MN_LDX, AM_ABS};
            8'hBE: r = '{1'b1, MN_LDX, AM_ABY};
            8'hA0: r = '{1'b1, MN_LDY, AM_IMM};  8'hA4: r = '{1'b1, MN_LDY, AM_ZP};
            8'hB4: r = '{1'b1, MN_LDY, AM_ZPX};  8'hAC: r = '{1'b1, MN_LDY, AM_ABS};
            8'hBC: r = '{1'b1, MN_LDY, AM_ABX};
            8'h4A: r = '{1'b1, MN_LSR, AM_ACC};  8'h46: r = '{1'b1, MN_LSR, AM_ZP};
            8'h56: r = '{1'b1, MN_LSR, AM_ZPX};  8'h4E: r = '{1'b1, MN_LSR, AM_ABS};
            8'h5E: r = '{1'b1, MN_LSR, AM_ABX};  8'hEA: r = '{1'b1, MN_NOP, AM_IMP};
            8'h09: r = '{1'b1, MN_ORA, AM_IMM};  8'h05: r = '{1'b1, MN_ORA, AM_ZP};
            8'h15: r = '{1'b1, MN_ORA, AM_ZPX};  8'h0D: r = '{1'b1, MN_ORA, AM_ABS};
            8'h1D: r = '{1'b1, MN_ORA, AM_ABX};  8'h19: r = '{1'b1, MN_ORA, AM_ABY};
            8'h01: r = '{1'b1, MN_ORA, AM_IZX};  8'h11: r = '{1'b1, MN_ORA, AM_IZY};
            8'h48: r = '{1'b1, MN_PHA, AM_IMP};  8'h08: r = '{1'b1, MN_PHP, AM_IMP};
            8'h68: r = '{1'b1, MN_PLA, AM_IMP};  8'h28: r = '{1'b1, MN_PLP, AM_IMP};
            8'h2A: r = '{1'b1, MN_ROL, AM_ACC};  8'h26: r = '{1'b1, MN_ROL, AM_ZP};
            8'h36: r = '{1'b1, MN_ROL, AM_ZPX};  8'h2E: r = '{1'b1, MN_ROL, AM_ABS};
            8'h3E: r = '{1'b1, MN_ROL, AM_ABX};
            8'h6A: r = '{1'b1, MN_ROR, AM_ACC};  8'h66: r = '{1'b1, MN_ROR, AM_ZP};
            8'h76: r = '{1'b1, MN_ROR, AM_ZPX};  8'h6E: r = '{1'b1, MN_ROR, AM_ABS};
            8'h7E: r = '{1'b1, MN_ROR, AM_ABX};
            8'h40: r = '{1'b1, MN_RTI, AM_IMP};  8'h60: r = '{1'b1, MN_RTS, AM_IMP};
            8'hE9: r = '{1'b1, MN_SBC, AM_IMM};  8'hE5: r = '{1'b1, MN_SBC, AM_ZP};
            8'hF5: r = '{1'b1, MN_SBC, AM_ZPX};  8'hED: r = '{1'b1, MN_SBC, AM_ABS};
            8'hFD: r = '{1'b1, MN_SBC, AM_ABX};  8'hF9: r = '{1'b1, MN_SBC, AM_ABY};
            8'hE1: r = '{1'b1, MN_SBC, AM_IZX};  8'hF1: r = '{1'b1, MN_SBC, AM_IZY};
            8'h38: r = '{1'b1, MN_SEC, AM_IMP};  8'hF8: r = '{1'b1, MN_SED, AM_IMP};
            8'h78: r = '{1'b1, MN_SEI, AM_IMP};
            8'h85: r = '{1'b1, MN_STA, AM_ZP};   8'h95: r = '{1'b1, MN_STA, AM_ZPX};
            8'h8D: r = '{1'b1, MN_STA, AM_ABS};  8'h9D: r = '{1'b1, MN_STA, AM_ABX};
            8'h99: r = '{1'b1, MN_STA, AM_ABY};  8'h81: r = '{1'b1, MN_STA, AM_IZX};
            8'h91: r = '{1'b1, MN_STA, AM_IZY};  8'h92: r = '{1'b1, MN_STA, AM_ZPI};
            8'h86: r = '{1'b1, MN_STX, AM_ZP};   8'h96: r = '{1'b1, MN_STX, AM_ZPY};
            8'h8E: r = '{1'b1, MN_STX, AM_ABS};  8'h84: r = '{1'b1, MN_STY, AM_ZP};
            8'h94: r = '{1'b1, MN_STY, AM_ZPX};  8'h8C: r = '{1'b1, MN_STY, AM_ABS};
            8'hAA: r = '{1'b1, MN_TAX, AM_IMP};  8'hA8: r = '{1'b1, MN_TAY, AM_IMP};
            8'hBA: r = '{1'b1, MN_TSX, AM_IMP};  8'h8A: r = '{1'b1, MN_TXA, AM_IMP};
            8'h9A: r = '{1'b1, MN_TXS, AM_IMP};  8'h98: r = '{1'b1, MN_TYA, AM_IMP};
            default: r = '{1'b0, MN_ADC, AM_IMP};
        endcase
        return r;
    endfunction

endpackage

[design/cpu6502_instruction_predecoder.sv]
// 6502 instruction predecoder: code byte stream in, one record per instruction out.
// Takes one code byte per cycle unless the output stalls; each byte is decoded in a
// single pass from the input handshake into the stream state or output register.
// A record is registered and presented in the cycle after its last byte is accepted.
// Throughput: one byte per cycle, limited only by output backpressure.
// Reset: synchronous; stream restarts at address 0 with end address 0xFFFF.
`include "cpu6502_instruction_predecoder_macros.svh"

module cpu6502_instruction_predecoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // code byte stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,      // [7:0] code_byte
    // decoded record stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] instr_address, [23:16] opcode_byte, [29:24] mnemonic_index,
    // [33:30] address_mode, [35:34] instr_length, [51:36] operand_value, [55:52] zero
    output logic [55:0] o_m_tdata,
    output logic        o_m_tuser,      // [0] opcode_valid
    output logic        o_m_tlast       // reached_end
);

    // Stream state
    logic [15:0]       r_end_addr;
    logic [15:0]       r_next_addr, n_next_addr;
    logic [15:0]       r_instr_start, n_instr_start;
    logic [7:0]        r_held_op, n_held_op;
    p65_pkg::t_mnem    r_held_mnem, n_held_mnem;
    p65_pkg::t_mode    r_held_mode, n_held_mode;
    logic [7:0]        r_low_byte, n_low_byte;
    logic [1:0]        r_pending, n_pending;
    logic              r_stopped, n_stopped;

    // Output register
    logic              r_out_valid;
    logic [51:0]       r_out_data, n_out_data;
    logic              r_out_user, n_out_user;
    logic              r_out_last, n_out_last;

    logic              s_accept;
    logic              emit;
    logic              start_write;
    logic [15:0]       next_inc;
    logic [15:0]       branch_target;
    logic [1:0]        op_len;
    p65_pkg::t_op_info op_info;

    // Take a new byte whenever the output slot is free or draining
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign start_write = i_cfg_we && (i_cfg_index == p65_pkg::CFG_START);

    assign op_info       = p65_pkg::decode_op(i_s_tdata);
    assign op_len        = p65_pkg::mode_length(op_info.mode);
    assign next_inc      = r_next_addr + 16'd1;
    assign branch_target = r_instr_start + 16'd2 + {{8{i_s_tdata[7]}}, i_s_tdata};

    // Decode the accepted byte against the stream state
    always_comb begin
        n_next_addr   = r_next_addr;
        n_instr_start = r_instr_start;
        n_held_op     = r_held_op;
        n_held_mnem   = r_held_mnem;
        n_held_mode   = r_held_mode;
        n_low_byte    = r_low_byte;
        n_pending     = r_pending;
        n_stopped     = r_stopped;
        emit          = 1'b0;
        n_out_data    = r_out_data;
        n_out_user    = r_out_user;
        n_out_last    = next_inc >= r_end_addr;
        if (s_accept && !r_stopped) begin
            if (r_pending == 2'd0) begin
                if (r_next_addr >= r_end_addr) begin
                    n_stopped = 1'b1;
                end else begin
                    n_instr_start = r_next_addr;
                    n_next_addr   = next_inc;
                    n_held_op     = i_s_tdata;
                    n_held_mnem   = op_info.mnem;
                    n_held_mode   = op_info.mode;
                    if (!op_info.valid) begin
                        emit       = 1'b1;
                        n_out_data = {8'd0, i_s_tdata, 2'd1, p65_pkg::AM_IMP,
                                      p65_pkg::MN_ADC, i_s_tdata, r_next_addr};
                        n_out_user = 1'b0;
                    end else if (op_len == 2'd1) begin
                        emit       = 1'b1;
                        n_out_data = {16'd0, 2'd1, op_info.mode, op_info.mnem,
                                      i_s_tdata, r_next_addr};
                        n_out_user = 1'b1;
                    end else begin
                        n_pending = op_len - 2'd1;
                    end
                end
            end else begin
                n_next_addr = next_inc;
                if (r_pending == 2'd2) begin
                    n_low_byte = i_s_tdata;
                    n_pending  = 2'd1;
                end else begin
                    emit       = 1'b1;
                    n_out_user = 1'b1;
                    if (p65_pkg::mode_length(r_held_mode) == 2'd3) begin
                        n_out_data = {i_s_tdata, r_low_byte, 2'd3, r_held_mode,
                                      r_held_mnem, r_held_op, r_instr_start};
                    end else if (r_held_mode == p65_pkg::AM_REL) begin
                        n_out_data = {branch_target, 2'd2, r_held_mode,
                                      r_held_mnem, r_held_op, r_instr_start};
                    end else begin
                        n_out_data = {8'd0, i_s_tdata, 2'd2, r_held_mode,
                                      r_held_mnem, r_held_op, r_instr_start};
                    end
                end
            end
        end
        // Close out the instruction and stop at the end address
        if (emit) begin
            n_pending = 2'd0;
            if (n_out_last) begin
                n_stopped = 1'b1;
            end
        end
        // Restart the stream on a start address write
        if (start_write) begin
            n_next_addr = i_cfg_data;
            n_pending   = 2'd0;
            n_stopped   = 1'b0;
        end
    end

    // Hold stream state and the end address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_addr  <= 16'hFFFF;
            r_next_addr <= 16'd0;
            r_pending   <= 2'd0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_next_addr <= n_next_addr;
            r_pending   <= n_pending;
            r_stopped   <= n_stopped;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we && (i_cfg_index == p65_pkg::CFG_END)) begin
                r_end_addr <= i_cfg_data;
            end
        end
    end

    // Payload registers; the output fields are loaded only with a new record
    always_ff @(posedge i_clk) begin
        r_instr_start <= n_instr_start;
        r_held_op     <= n_held_op;
        r_held_mnem   <= n_held_mnem;
        r_held_mode   <= n_held_mode;
        r_low_byte    <= n_low_byte;
        if (emit) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
            r_out_last <= n_out_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_data};
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

    `P65_ASSERT_ALWAYS(a_pending_range, r_pending != 2'd3, "operand count out of range")
    `P65_ASSERT_ALWAYS(a_len_matches_mode,
        !r_out_valid || (r_out_user ? (r_out_data[35:34] ==
            p65_pkg::mode_length(r_out_data[33:30])) :
            (r_out_data[35:34] == 2'd1 && r_out_data[33:30] == p65_pkg::AM_IMP)),
        "record length does not match addressing mode")
    `P65_ASSERT_NEXT(a_last_stops, emit && n_out_last && !start_write,
        r_stopped, "decoder kept running after the end record")
    `P65_ASSERT_NEXT(a_operand_advances,
        s_accept && !r_stopped && r_pending != 2'd0 && !start_write,
        r_next_addr == $past(r_next_addr) + 16'd1, "operand byte did not advance address")

endmodule
